[hw/rtl/tbc8_pkg.sv]
package tbc8_pkg;

	localparam logic [31:0] SUM_STEP = 32'h9e3779b9;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_SEED     = 1'b0,
		REG_DECRYPT_MODE = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] v0;
		logic [31:0] v1;
	} blk_t;

	typedef struct packed {
		logic [31:0] k0;
		logic [31:0] k1;
		logic [31:0] k2;
		logic [31:0] k3;
	} key_t;

	function automatic logic [31:0] round_mix(input logic [31:0] v, input logic [31:0] ka,
			input logic [31:0] kb, input logic [31:0] sum);
		round_mix = ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
	endfunction

endpackage

[hw/rtl/tbc8_cell.sv]
module tbc8_cell import tbc8_pkg::*; #(
	parameter bit          Half   = 1'b0,
	parameter logic [31:0] EncSum = 32'h0,
	parameter logic [31:0] DecSum = 32'h0
) (
	input  logic clk,
	input  logic arst_n,
	input  key_t key,
	input  logic decrypt,
	input  logic in_valid,
	output logic in_ready,
	input  blk_t in_blk,
	output logic out_valid,
	input  logic out_ready,
	output blk_t out_blk
);

	logic        valid_q;
	blk_t        blk_q;
	logic        upd_v0;
	logic [31:0] sum;
	logic [31:0] src;
	logic [31:0] dst;
	logic [31:0] ka;
	logic [31:0] kb;
	logic [31:0] mix_w;
	logic [31:0] new_w;
	blk_t        nxt_blk;

	// encrypt: first half updates v0, second v1; decrypt runs them in reverse
	assign upd_v0 = Half ^ ~decrypt;
	assign sum    = decrypt ? DecSum : EncSum;
	assign src    = upd_v0 ? in_blk.v1 : in_blk.v0;
	assign dst    = upd_v0 ? in_blk.v0 : in_blk.v1;
	assign ka     = upd_v0 ? key.k0 : key.k2;
	assign kb     = upd_v0 ? key.k1 : key.k3;
	assign mix_w  = round_mix(src, ka, kb, sum);
	assign new_w  = decrypt ? (dst - mix_w) : (dst + mix_w);

	always_comb begin
		nxt_blk = in_blk;
		if (upd_v0) begin
			nxt_blk.v0 = new_w;
		end else begin
			nxt_blk.v1 = new_w;
		end
	end

	assign in_ready  = ~valid_q | out_ready;
	assign out_valid = valid_q;
	assign out_blk   = blk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			blk_q <= nxt_blk;
		end
	end

endmodule

[hw/rtl/tea_block_cipher_8round_core.sv]
// TEA block cipher core, ROUNDS rounds (8 by default), one 64-bit block per
// request as word_low/word_high, result on out_low/out_high. The datapath is a
// chain of 2*ROUNDS half-round cells, each with its own register stage; a
// request passes through the cell registers in order to the output, and one
// request per cycle is sustained while out_ready stays high. A cell frees up
// as soon as its content moves on, so requests keep entering while a result
// waits at the output until the chain is full. Register 0 is the signed key
// seed (the four key words are derived on write), register 1 selects
// decryption; write them only while no request is in flight.
module tea_block_cipher_8round_core import tbc8_pkg::*; #(
	parameter int ROUNDS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [31:0]          word_low,
	input  logic [31:0]          word_high,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          out_low,
	output logic [31:0]          out_high
);

	localparam int NCELL = 2 * ROUNDS;

	key_t              key_q;
	logic              mode_q;
	blk_t              chain [NCELL+1];
	logic [NCELL:0]    vld;
	logic [NCELL:0]    rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= '0;
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_KEY_SEED: begin
					key_q.k0 <= cfg_data;
					key_q.k1 <= cfg_data ^ 32'($signed(cfg_data) >>> 1);
					key_q.k2 <= cfg_data ^ 32'($signed(cfg_data) >>> 2);
					key_q.k3 <= cfg_data ^ 32'($signed(cfg_data) >>> 3);
				end
				REG_DECRYPT_MODE: begin
					mode_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign chain[0]     = '{v0: word_low, v1: word_high};
	assign vld[0]       = in_valid;
	assign in_ready     = rdy[0];
	assign rdy[NCELL]   = out_ready;
	assign out_valid    = vld[NCELL];
	assign out_low      = chain[NCELL].v0;
	assign out_high     = chain[NCELL].v1;

	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		localparam logic [63:0] EncProd = 64'(SUM_STEP) * 64'(g / 2 + 1);
		localparam logic [63:0] DecProd = 64'(SUM_STEP) * 64'(ROUNDS - g / 2);

		tbc8_cell #(
			.Half   (bit'(g % 2)),
			.EncSum (EncProd[31:0]),
			.DecSum (DecProd[31:0])
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.key       (key_q),
			.decrypt   (mode_q),
			.in_valid  (vld[g]),
			.in_ready  (rdy[g]),
			.in_blk    (chain[g]),
			.out_valid (vld[g+1]),
			.out_ready (rdy[g+1]),
			.out_blk   (chain[g+1])
		);
	end

`ifndef SYNTH
	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("output stage empty but input not ready");

	a_accept_fills_first: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld[1])
		else $error("accepted request did not enter first cell");

	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> ($countones(vld[NCELL:1]) == $past($countones(vld[NCELL:1]))
			+ int'($past(in_valid && in_ready)) - int'($past(out_valid && out_ready))))
		else $error("request lost or duplicated in cell chain");
`endif

endmodule
